// File: rtl/sofr_pkg.sv
// ----------------------------------------------------------------------------
// sofr_pkg
// Shared types, register indexes, event codes and CRC helpers for the
// start-of-frame / length / CRC frame receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sofr_pkg;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;

	localparam logic [CFG_INDEX_W-1:0] CFG_START_BYTE      = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_HEADER_CRC_POLY = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_HEADER_CRC_INIT = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_CRC_POLY  = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_CRC_INIT  = 3'd4;

	localparam logic [7:0]  START_BYTE_RST      = 8'hA5;
	localparam logic [7:0]  HEADER_CRC_POLY_RST = 8'h8C;
	localparam logic [7:0]  HEADER_CRC_INIT_RST = 8'hFF;
	localparam logic [15:0] FRAME_CRC_POLY_RST  = 16'h8408;
	localparam logic [15:0] FRAME_CRC_INIT_RST  = 16'hFFFF;

	localparam int HEADER_BYTES   = 5;
	localparam int OVERHEAD_BYTES = 9;
	localparam int CMD_LO_POS     = HEADER_BYTES;
	localparam int CMD_HI_POS     = HEADER_BYTES + 1;
	localparam int PAYLOAD_POS    = HEADER_BYTES + 2;

	localparam int RES_QUEUE_DEPTH = 4;

	localparam logic FUNC_RECEIVE = 1'b0;
	localparam logic FUNC_READ    = 1'b1;

	typedef enum logic [1:0] {
		EV_NONE = 2'd0,
		EV_OK   = 2'd1,
		EV_HDR  = 2'd2,
		EV_CRC  = 2'd3
	} event_t;

	typedef struct packed {
		event_t      event_res;
		logic [15:0] command_id;
		logic [6:0]  payload_length;
		logic [7:0]  sequence_res;
		logic [7:0]  read_data;
	} result_t;

	// Reflected CRC-8, one byte, LSB first.
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b,
			input logic [7:0] poly);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
		end
		return c;
	endfunction

	// Reflected CRC-16, one byte, LSB first.
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b,
			input logic [15:0] poly);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// File: rtl/sofr_if.sv
// ----------------------------------------------------------------------------
// sofr_in_if / sofr_out_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface sofr_in_if;
	logic       valid;
	logic       ready;
	logic       func;
	logic [7:0] rx_byte;
	logic [6:0] read_index;

	modport source (output valid, func, rx_byte, read_index, input ready);
	modport sink   (input valid, func, rx_byte, read_index, output ready);
endinterface

interface sofr_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  event_res;
	logic [15:0] command_id;
	logic [6:0]  payload_length;
	logic [7:0]  sequence_res;
	logic [7:0]  read_data;

	modport source (output valid, event_res, command_id, payload_length, sequence_res,
		read_data, input ready);
	modport sink   (input valid, event_res, command_id, payload_length, sequence_res,
		read_data, output ready);
endinterface

`default_nettype wire

// File: rtl/sofr_front.sv
// ----------------------------------------------------------------------------
// sofr_front
// Accepts items, runs the frame parser and both CRCs, writes the two-bank
// payload store and reads it for read items. Results leave through one
// register stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sofr_front #(
	parameter int FRAME_MAX_BYTES = 128
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 cfg_we,
	input  wire [sofr_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  wire [sofr_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	input  wire                                 in_valid,
	output logic                                in_ready,
	input  wire                                 in_func,
	input  wire [7:0]                           in_rx_byte,
	input  wire [6:0]                           in_read_index,
	output logic                                res_valid,
	input  wire                                 res_ready,
	output sofr_pkg::result_t                   res
);

	localparam int AW = $clog2(FRAME_MAX_BYTES);
	localparam int TW = AW + 1;
	localparam int PW = (AW > 8) ? AW : 8;
	localparam int LEN_LIMIT = FRAME_MAX_BYTES - sofr_pkg::OVERHEAD_BYTES;

	typedef enum logic [5:0] {
		ST_HUNT   = 6'b000001,
		ST_LEN_LO = 6'b000010,
		ST_LEN_HI = 6'b000100,
		ST_SEQ    = 6'b001000,
		ST_HCRC   = 6'b010000,
		ST_BODY   = 6'b100000
	} parse_t;

	// configuration
	logic [7:0]  start_byte_q, hcrc_poly_q, hcrc_init_q;
	logic [15:0] fcrc_poly_q, fcrc_init_q;

	// parser state
	parse_t      step_q, step_d;
	logic [AW-1:0] pos_q, pos_d;
	logic [7:0]  len_lo_q, len_lo_d;
	logic [AW-1:0] len_q, len_d;
	logic [7:0]  seq_q, seq_d;
	logic [7:0]  cmd_lo_q, cmd_lo_d, cmd_hi_q, cmd_hi_d;
	logic [7:0]  prev_q, prev_d;
	logic [7:0]  hcrc_q, hcrc_d;
	logic [15:0] fcrc_q, fcrc_d;
	logic        bank_q, bank_d;
	logic [15:0] good_cmd_q, good_cmd_d;
	logic [AW-1:0] good_len_q, good_len_d;
	logic [7:0]  good_seq_q, good_seq_d;
	sofr_pkg::event_t ev_d;
	logic        wr_en;

	logic        accept, rx_acc, rd_acc;
	logic [15:0] len_full;
	logic [TW-1:0] total, pos_ext;
	logic [PW-1:0] rd_pos;
	logic        rd_ok;

	// result stage
	logic        valid_s1;
	sofr_pkg::event_t ev_s1;
	logic [15:0] cmd_s1;
	logic [AW-1:0] len_s1;
	logic [7:0]  seq_s1;
	logic        rd_ok_s1;
	logic [7:0]  rd_data_s1;
	logic [PW-1:0] len_s1_ext;

	// bank select on the top address bit, each bank a power of two deep
	logic [7:0]  mem [2**TW];

	assign in_ready = !valid_s1 || res_ready;
	assign accept   = in_valid && in_ready;
	assign rx_acc   = accept && (in_func == sofr_pkg::FUNC_RECEIVE);
	assign rd_acc   = accept && (in_func == sofr_pkg::FUNC_READ);

	assign len_full = {in_rx_byte, len_lo_q};
	assign total    = TW'(sofr_pkg::OVERHEAD_BYTES) + TW'(len_q);
	assign pos_ext  = TW'(pos_q);
	assign rd_pos   = PW'(sofr_pkg::PAYLOAD_POS) + PW'(in_read_index);
	assign rd_ok    = PW'(in_read_index) < PW'(good_len_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q <= sofr_pkg::START_BYTE_RST;
			hcrc_poly_q  <= sofr_pkg::HEADER_CRC_POLY_RST;
			hcrc_init_q  <= sofr_pkg::HEADER_CRC_INIT_RST;
			fcrc_poly_q  <= sofr_pkg::FRAME_CRC_POLY_RST;
			fcrc_init_q  <= sofr_pkg::FRAME_CRC_INIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sofr_pkg::CFG_START_BYTE:      start_byte_q <= cfg_wdata[7:0];
				sofr_pkg::CFG_HEADER_CRC_POLY: hcrc_poly_q  <= cfg_wdata[7:0];
				sofr_pkg::CFG_HEADER_CRC_INIT: hcrc_init_q  <= cfg_wdata[7:0];
				sofr_pkg::CFG_FRAME_CRC_POLY:  fcrc_poly_q  <= cfg_wdata;
				sofr_pkg::CFG_FRAME_CRC_INIT:  fcrc_init_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		step_d     = step_q;
		pos_d      = pos_q;
		len_lo_d   = len_lo_q;
		len_d      = len_q;
		seq_d      = seq_q;
		cmd_lo_d   = cmd_lo_q;
		cmd_hi_d   = cmd_hi_q;
		prev_d     = prev_q;
		hcrc_d     = hcrc_q;
		fcrc_d     = fcrc_q;
		bank_d     = bank_q;
		good_cmd_d = good_cmd_q;
		good_len_d = good_len_q;
		good_seq_d = good_seq_q;
		ev_d       = sofr_pkg::EV_NONE;
		wr_en      = 1'b0;
		if (rx_acc) begin
			unique case (step_q)
				ST_HUNT: begin
					pos_d = '0;
					if (in_rx_byte == start_byte_q) begin
						wr_en  = 1'b1;
						hcrc_d = sofr_pkg::crc8_byte(hcrc_init_q, in_rx_byte, hcrc_poly_q);
						fcrc_d = sofr_pkg::crc16_byte(fcrc_init_q, in_rx_byte, fcrc_poly_q);
						pos_d  = AW'(1);
						step_d = ST_LEN_LO;
					end
				end
				ST_LEN_LO: begin
					wr_en    = 1'b1;
					len_lo_d = in_rx_byte;
					hcrc_d   = sofr_pkg::crc8_byte(hcrc_q, in_rx_byte, hcrc_poly_q);
					fcrc_d   = sofr_pkg::crc16_byte(fcrc_q, in_rx_byte, fcrc_poly_q);
					pos_d    = pos_q + AW'(1);
					step_d   = ST_LEN_HI;
				end
				ST_LEN_HI: begin
					wr_en  = 1'b1;
					hcrc_d = sofr_pkg::crc8_byte(hcrc_q, in_rx_byte, hcrc_poly_q);
					fcrc_d = sofr_pkg::crc16_byte(fcrc_q, in_rx_byte, fcrc_poly_q);
					if (len_full < 16'(LEN_LIMIT)) begin
						len_d  = len_full[AW-1:0];
						pos_d  = pos_q + AW'(1);
						step_d = ST_SEQ;
					end else begin
						pos_d  = '0;
						step_d = ST_HUNT;
						ev_d   = sofr_pkg::EV_HDR;
					end
				end
				ST_SEQ: begin
					wr_en  = 1'b1;
					seq_d  = in_rx_byte;
					hcrc_d = sofr_pkg::crc8_byte(hcrc_q, in_rx_byte, hcrc_poly_q);
					fcrc_d = sofr_pkg::crc16_byte(fcrc_q, in_rx_byte, fcrc_poly_q);
					pos_d  = pos_q + AW'(1);
					step_d = ST_HCRC;
				end
				ST_HCRC: begin
					wr_en  = 1'b1;
					fcrc_d = sofr_pkg::crc16_byte(fcrc_q, in_rx_byte, fcrc_poly_q);
					if (hcrc_q == in_rx_byte) begin
						pos_d  = pos_q + AW'(1);
						step_d = ST_BODY;
					end else begin
						pos_d  = '0;
						step_d = ST_HUNT;
						ev_d   = sofr_pkg::EV_HDR;
					end
				end
				ST_BODY: begin
					wr_en  = 1'b1;
					prev_d = in_rx_byte;
					// the two trailing CRC bytes stay out of the running CRC
					if (pos_ext + TW'(2) < total) begin
						fcrc_d = sofr_pkg::crc16_byte(fcrc_q, in_rx_byte, fcrc_poly_q);
					end
					if (pos_q == AW'(sofr_pkg::CMD_LO_POS)) begin
						cmd_lo_d = in_rx_byte;
					end
					if (pos_q == AW'(sofr_pkg::CMD_HI_POS)) begin
						cmd_hi_d = in_rx_byte;
					end
					if (pos_ext + TW'(1) < total) begin
						pos_d = pos_q + AW'(1);
					end else begin
						pos_d  = '0;
						step_d = ST_HUNT;
						if ({in_rx_byte, prev_q} != fcrc_q) begin
							ev_d = sofr_pkg::EV_CRC;
						end else begin
							ev_d       = sofr_pkg::EV_OK;
							good_cmd_d = {cmd_hi_q, cmd_lo_q};
							good_len_d = len_q;
							good_seq_d = seq_q;
							bank_d     = !bank_q;
						end
					end
				end
				default: begin
					pos_d  = '0;
					step_d = ST_HUNT;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q     <= ST_HUNT;
			pos_q      <= '0;
			len_lo_q   <= '0;
			len_q      <= '0;
			hcrc_q     <= sofr_pkg::HEADER_CRC_INIT_RST;
			fcrc_q     <= sofr_pkg::FRAME_CRC_INIT_RST;
			bank_q     <= 1'b0;
			good_cmd_q <= '0;
			good_len_q <= '0;
			good_seq_q <= '0;
			valid_s1   <= 1'b0;
		end else begin
			step_q     <= step_d;
			pos_q      <= pos_d;
			len_lo_q   <= len_lo_d;
			len_q      <= len_d;
			hcrc_q     <= hcrc_d;
			fcrc_q     <= fcrc_d;
			bank_q     <= bank_d;
			good_cmd_q <= good_cmd_d;
			good_len_q <= good_len_d;
			good_seq_q <= good_seq_d;
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		seq_q    <= seq_d;
		cmd_lo_q <= cmd_lo_d;
		cmd_hi_q <= cmd_hi_d;
		prev_q   <= prev_d;
		if (accept) begin
			ev_s1    <= ev_d;
			cmd_s1   <= good_cmd_d;
			len_s1   <= good_len_d;
			seq_s1   <= good_seq_d;
			rd_ok_s1 <= rd_acc && rd_ok;
		end
	end

	// fill bank is the one not being read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[{!bank_q, pos_q}] <= in_rx_byte;
		end
		if (rd_acc) begin
			rd_data_s1 <= mem[{bank_q, rd_pos[AW-1:0]}];
		end
	end

	assign len_s1_ext         = PW'(len_s1);
	assign res_valid          = valid_s1;
	assign res.event_res      = ev_s1;
	assign res.command_id     = cmd_s1;
	assign res.payload_length = len_s1_ext[6:0];
	assign res.sequence_res   = seq_s1;
	assign res.read_data      = rd_ok_s1 ? rd_data_s1 : 8'h00;

endmodule

`default_nettype wire

// File: rtl/sofr_queue.sv
// ----------------------------------------------------------------------------
// sofr_queue
// Short result queue between the parser front and the output channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sofr_queue (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                push_valid,
	output logic               push_ready,
	input  sofr_pkg::result_t  push_data,
	output logic               pop_valid,
	input  wire                pop_ready,
	output sofr_pkg::result_t  pop_data
);

	localparam int DEPTH = sofr_pkg::RES_QUEUE_DEPTH;
	localparam int IW    = $clog2(DEPTH);

	sofr_pkg::result_t entry_q [DEPTH];
	logic [IW-1:0] wr_ptr_q, rd_ptr_q;
	logic [IW:0]   count_q;
	logic          push, pop;

	assign push_ready = count_q != (IW+1)'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + IW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + IW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (IW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (IW+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

// File: rtl/sof_length_crc_frame_receiver.sv
// One item is taken every cycle while the output side keeps up: receive items
// advance the frame parser one byte each, read items fetch one payload byte
// of the last good frame from a two-bank store (one bank fills while the
// other is read). A result passes through the result register, which holds
// the parser outcome and the registered store read, and then through the
// four-entry result queue. While the output side stalls, input keeps flowing
// for five more items (four held in the queue, one in the result register)
// before the input ready drops.
// ----------------------------------------------------------------------------
// sof_length_crc_frame_receiver
// Start-byte / length / sequence / CRC-8 header / CRC-16 frame deframer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sof_length_crc_frame_receiver #(
	parameter int FRAME_MAX_BYTES = 128
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cfg_we,
	input  wire [sofr_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  wire [sofr_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	sofr_in_if.sink                          in_ch,
	sofr_out_if.source                       out_ch
);

	logic              res_valid, res_ready;
	sofr_pkg::result_t res, head;

	sofr_front #(
		.FRAME_MAX_BYTES(FRAME_MAX_BYTES)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_ch.valid),
		.in_ready     (in_ch.ready),
		.in_func      (in_ch.func),
		.in_rx_byte   (in_ch.rx_byte),
		.in_read_index(in_ch.read_index),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.res          (res)
	);

	sofr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(res_valid),
		.push_ready(res_ready),
		.push_data (res),
		.pop_valid (out_ch.valid),
		.pop_ready (out_ch.ready),
		.pop_data  (head)
	);

	assign out_ch.event_res      = head.event_res;
	assign out_ch.command_id     = head.command_id;
	assign out_ch.payload_length = head.payload_length;
	assign out_ch.sequence_res   = head.sequence_res;
	assign out_ch.read_data      = head.read_data;

	// events come only from receive items, which never carry read data
	a_event_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && (out_ch.event_res != sofr_pkg::EV_NONE) |-> out_ch.read_data == 8'h00)
		else $error("event reported together with read data");

	// with the output empty, a taken item reaches the output through the result register and the result queue
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready && !out_ch.valid |=> ##1 out_ch.valid)
		else $error("taken item did not reach the output");

endmodule

`default_nettype wire
